>>> src/mph_pkg.sv
`default_nettype none

package mph_pkg;

  // Default number of heap slots
  localparam int HEAP_CAPACITY = 64;

  // Field widths
  localparam int ID_W  = 16;
  localparam int PRI_W = 32;
  localparam int ENT_W = ID_W + PRI_W;
  localparam int CFG_W = 7;

  // Reset value of the capacity register
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_EXTRACTED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_insert;  // latch new entry, open slot at the end
    logic set_drop;     // report a dropped insert
    logic set_empty;    // report an extract from an empty heap
    logic rd_parent;    // read the parent of the current slot
    logic up_step;      // move parent down into the current slot
    logic rd_ex;        // read root and last slot
    logic ex_load;      // take root as result, last entry as moving entry
    logic rd_children;  // read both children of the current slot
    logic dn_step;      // move the larger child up into the current slot
    logic wr_moving;    // write the moving entry into the current slot
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;        // count at or above effective capacity
    logic empty;       // count is zero
    logic at_root;     // current slot is the root
    logic up_greater;  // moving entry beats its parent
    logic no_left;     // current slot has no left child
    logic best_is_pos; // moving entry beats or ties both children
  } sts_t;

endpackage

`default_nettype wire

>>> src/mph_ram.sv
`default_nettype none

module mph_ram
  import mph_pkg::*;
#(
  parameter int WIDTH = ENT_W,
  parameter int DEPTH = HEAP_CAPACITY
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr0,
  input  wire  [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one slot, read two slots with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

>>> src/mph_ctrl.sv
`default_nettype none

module mph_ctrl
  import mph_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire        op,
  input  wire sts_t  sts,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_CHK = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_EX_LD  = 8'b0000_1000,
    S_DN_CHK = 8'b0001_0000,
    S_DN_CMP = 8'b0010_0000,
    S_FINISH = 8'b0100_0000,
    S_SPARE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_INSERT) begin
            if (sts.full) begin
              cmd.set_drop = 1'b1;
              state_next   = S_FINISH;
            end else begin
              cmd.load_insert = 1'b1;
              state_next      = S_UP_CHK;
            end
          end else begin
            if (sts.empty) begin
              cmd.set_empty = 1'b1;
              state_next    = S_FINISH;
            end else begin
              cmd.rd_ex  = 1'b1;
              state_next = S_EX_LD;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (sts.at_root) begin
          cmd.wr_moving = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_greater) begin
          cmd.up_step = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          cmd.wr_moving = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_EX_LD: begin
        cmd.ex_load = 1'b1;
        state_next  = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.no_left) begin
          cmd.wr_moving = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.rd_children = 1'b1;
          state_next      = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.best_is_pos) begin
          cmd.wr_moving = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.dn_step = 1'b1;
          state_next  = S_DN_CHK;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FINISH);

  // A result frees the block on the next cycle
  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block still busy after result strobe");

  // An accepted transaction occupies the block
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not occupy the block");

endmodule

`default_nettype wire

>>> src/mph_dpath.sv
`default_nettype none

module mph_dpath
  import mph_pkg::*;
#(
  parameter int CAPACITY = HEAP_CAPACITY
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire        [CFG_W-1:0]           cfg_wdata,
  input  wire        [ID_W-1:0]            item_id,
  input  wire        [PRI_W-1:0]           item_priority,
  input  wire cmd_t                        cmd,
  output sts_t                             sts,
  output logic       [1:0]                 status,
  output logic       [ID_W-1:0]            out_id,
  output logic signed [PRI_W-1:0]          out_priority,
  output logic       [$clog2(CAPACITY+1)-1:0] entry_total,
  output logic                             is_empty
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int LW    = AW + 2;

  logic [CFG_W-1:0]        cap_reg;
  logic [CNT_W-1:0]        count;
  logic [AW-1:0]           pos;
  logic [ID_W-1:0]         mov_id;
  logic signed [PRI_W-1:0] mov_pri;

  logic                    we;
  logic [ENT_W-1:0]        wdata;
  logic [AW-1:0]           raddr0, raddr1;
  logic [ENT_W-1:0]        rdata0, rdata1;

  logic [AW-1:0]           parent;
  logic [LW-1:0]           left, right, count_l;
  logic [CMP_W-1:0]        cap_eff;
  logic signed [PRI_W-1:0] r0_pri, r1_pri;
  logic                    left_ok, right_ok, take_left, take_right;
  logic signed [PRI_W-1:0] best_pri;

  // Heap slot storage
  mph_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (pos),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // Index arithmetic around the current slot
  assign parent  = AW'((pos - 1'b1) >> 1);
  assign left    = {1'b0, pos, 1'b1};
  assign right   = left + 1'b1;
  assign count_l = LW'(count);

  // Saturate the capacity register at the slot count
  assign cap_eff = (CMP_W'(cap_reg) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(cap_reg);

  // Compare the moving entry against what was read
  assign r0_pri     = rdata0[PRI_W-1:0];
  assign r1_pri     = rdata1[PRI_W-1:0];
  assign left_ok    = (left < count_l);
  assign right_ok   = (right < count_l);
  assign take_left  = left_ok && (r0_pri > mov_pri);
  assign best_pri   = take_left ? r0_pri : mov_pri;
  assign take_right = right_ok && (r1_pri > best_pri);

  // Status to the controller
  always_comb begin
    sts.full        = (CMP_W'(count) >= cap_eff);
    sts.empty       = (count == '0);
    sts.at_root     = (pos == '0);
    sts.up_greater  = (mov_pri > r0_pri);
    sts.no_left     = !left_ok;
    sts.best_is_pos = !take_left && !take_right;
  end

  // Select read addresses
  always_comb begin
    raddr0 = parent;
    raddr1 = left[AW-1:0];
    if (cmd.rd_ex) begin
      raddr0 = '0;
      raddr1 = AW'(count - 1'b1);
    end else if (cmd.rd_children) begin
      raddr0 = left[AW-1:0];
      raddr1 = right[AW-1:0];
    end else if (cmd.rd_parent) begin
      raddr0 = parent;
    end
  end

  // Select write data: parent moves down, child moves up, or the moving entry lands
  always_comb begin
    we    = cmd.up_step | cmd.dn_step | cmd.wr_moving;
    wdata = {mov_id, mov_pri};
    if (cmd.up_step) begin
      wdata = rdata0;
    end else if (cmd.dn_step) begin
      wdata = take_right ? rdata1 : rdata0;
    end
  end

  // Hold control state: capacity register and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CFG_RESET;
      count   <= '0;
    end else begin
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
      end
      if (cmd.load_insert) begin
        count <= count + 1'b1;
      end else if (cmd.ex_load) begin
        count <= count - 1'b1;
      end
    end
  end

  // Track the current slot and the moving entry
  always_ff @(posedge clk) begin
    if (cmd.load_insert) begin
      pos     <= AW'(count);
      mov_id  <= item_id;
      mov_pri <= item_priority;
    end else if (cmd.ex_load) begin
      pos     <= '0;
      mov_id  <= rdata1[ENT_W-1:PRI_W];
      mov_pri <= r1_pri;
    end else if (cmd.up_step) begin
      pos <= parent;
    end else if (cmd.dn_step) begin
      pos <= take_right ? right[AW-1:0] : left[AW-1:0];
    end
  end

  // Latch result fields
  always_ff @(posedge clk) begin
    if (cmd.load_insert) begin
      status       <= ST_INSERTED;
      out_id       <= '0;
      out_priority <= '0;
    end else if (cmd.set_drop) begin
      status       <= ST_DROPPED;
      out_id       <= '0;
      out_priority <= '0;
    end else if (cmd.set_empty) begin
      status       <= ST_EMPTY;
      out_id       <= '0;
      out_priority <= '0;
    end else if (cmd.ex_load) begin
      status       <= ST_EXTRACTED;
      out_id       <= rdata0[ENT_W-1:PRI_W];
      out_priority <= r0_pri;
    end
  end

  assign entry_total = count;
  assign is_empty    = (count == '0);

  // Count never passes the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(CAPACITY))
    else $error("entry count above capacity");

  // An insert grows the heap by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_insert |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");

  // An extract shrinks the heap by one
  a_extract_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.ex_load |=> count == $past(count) - 1'b1)
    else $error("extract did not shrink the count");

endmodule

`default_nettype wire

>>> src/max_priority_heap.sv
`default_nettype none

// Binary max-heap of (id, signed priority) entries in one two-read-port RAM.
// Raise start for one cycle while busy is low; operation 0 inserts, 1 extracts
// the maximum. Each transaction gives exactly one result, shown for one cycle
// with done high; the receiver cannot stall it, so capture it on that cycle.
// Timing is set by the RAM's registered read: each tree level walked takes a read
// step, then a compare-and-move step. An insert rises until it reaches the root or
// its parent stops it; an extract sinks until it lands on a slot with no children
// or its children stop it. A dropped insert or an empty extract goes straight to
// its result, and start is taken again the cycle after done.
// Write cfg_we/cfg_wdata only while busy is low.
module max_priority_heap
  import mph_pkg::*;
#(
  parameter int CAPACITY = HEAP_CAPACITY
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire         [CFG_W-1:0]             cfg_wdata,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 operation,
  input  wire         [ID_W-1:0]              item_id,
  input  wire         [PRI_W-1:0]             item_priority,
  output logic                                done,
  output logic        [1:0]                   status,
  output logic        [ID_W-1:0]              out_id,
  output logic signed [PRI_W-1:0]             out_priority,
  output logic        [$clog2(CAPACITY+1)-1:0] entry_total,
  output logic                                is_empty
);

  cmd_t cmd;
  sts_t sts;

  // Sequence inserts and extracts
  mph_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (operation),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Storage, compares and result registers
  mph_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .item_id       (item_id),
    .item_priority (item_priority),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .out_id        (out_id),
    .out_priority  (out_priority),
    .entry_total   (entry_total),
    .is_empty      (is_empty)
  );

endmodule

`default_nettype wire

>>> dv/tb_max_priority_heap.sv
`timescale 1ns / 1ps

module tb_max_priority_heap;
  import mph_pkg::*;

  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 172;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [PRI_W-1:0]    pri;
    logic [CFG_W-1:0]    total;
    logic                empty;
  } heap_result_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CFG_W-1:0]    cap;
    logic                op;
    logic [ID_W-1:0]     id;
    logic [PRI_W-1:0]    pri;
    logic                typed;
    heap_result_t        want;
  } step_row_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    start;
  logic                    busy;
  logic                    operation;
  logic [ID_W-1:0]         item_id;
  logic [PRI_W-1:0]        item_priority;
  logic                    done;
  logic [1:0]              status;
  logic [ID_W-1:0]         out_id;
  logic signed [PRI_W-1:0] out_priority;
  logic [CFG_W-1:0]        entry_total;
  logic                    is_empty;

  // Shadow copy of the heap and its capacity register
  logic [ID_W-1:0]         shadow_id [HEAP_CAPACITY];
  logic signed [PRI_W-1:0] shadow_pri [HEAP_CAPACITY];
  int                      shadow_count;
  logic [CFG_W-1:0]        shadow_cap;

  heap_result_t results_due [$];
  heap_result_t due_head;
  heap_result_t no_want;
  step_row_t    directed [$];
  int           err_count;

  max_priority_heap dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .item_id       (item_id),
    .item_priority (item_priority),
    .done          (done),
    .status        (status),
    .out_id        (out_id),
    .out_priority  (out_priority),
    .entry_total   (entry_total),
    .is_empty      (is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void swap_slots(input int a, input int b);
    logic [ID_W-1:0]         tmp_id;
    logic signed [PRI_W-1:0] tmp_pri;
    tmp_id = shadow_id[a];
    tmp_pri = shadow_pri[a];
    shadow_id[a] = shadow_id[b];
    shadow_pri[a] = shadow_pri[b];
    shadow_id[b] = tmp_id;
    shadow_pri[b] = tmp_pri;
  endfunction

  // Apply one transaction to the shadow heap and return its result
  function automatic heap_result_t heap_predict(input logic op, input logic [ID_W-1:0] id,
                                                input logic signed [PRI_W-1:0] pri);
    heap_result_t r;
    int           eff_cap;
    int           pos;
    int           parent;
    int           left;
    int           right;
    int           best;
    eff_cap = (shadow_cap > HEAP_CAPACITY) ? HEAP_CAPACITY : int'(shadow_cap);
    r.status = ST_INSERTED;
    r.id = '0;
    r.pri = '0;
    if (op == OP_INSERT) begin
      if (shadow_count >= eff_cap) begin
        r.status = ST_DROPPED;
      end else begin
        pos = shadow_count;
        shadow_id[pos] = id;
        shadow_pri[pos] = pri;
        shadow_count++;
        // sift up while strictly greater than the parent
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(shadow_pri[pos] > shadow_pri[parent])) break;
          swap_slots(pos, parent);
          pos = parent;
        end
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_EXTRACTED;
      r.id = shadow_id[0];
      r.pri = shadow_pri[0];
      shadow_id[0] = shadow_id[shadow_count - 1];
      shadow_pri[0] = shadow_pri[shadow_count - 1];
      shadow_count--;
      // sift down toward the larger child, left wins ties, no swap on a tie
      pos = 0;
      while (1) begin
        left = 2 * pos + 1;
        right = left + 1;
        best = pos;
        if (left < shadow_count && shadow_pri[left] > shadow_pri[best]) best = left;
        if (right < shadow_count && shadow_pri[right] > shadow_pri[best]) best = right;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    end
    r.total = shadow_count[CFG_W-1:0];
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return PRI_W'($urandom_range(0, 6) - 3);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic step_row_t op_row(input logic op, input logic [ID_W-1:0] id,
                                       input logic [PRI_W-1:0] pri);
    step_row_t row;
    row = '0;
    row.op = op;
    row.id = id;
    row.pri = pri;
    return row;
  endfunction

  function automatic step_row_t typed_row(input logic op, input logic [ID_W-1:0] id,
                                          input logic [PRI_W-1:0] pri, input status_t st,
                                          input logic [ID_W-1:0] oid,
                                          input logic [PRI_W-1:0] opri,
                                          input logic [CFG_W-1:0] total);
    step_row_t row;
    row = op_row(op, id, pri);
    row.typed = 1'b1;
    row.want.status = st;
    row.want.id = oid;
    row.want.pri = opri;
    row.want.total = total;
    row.want.empty = (total == 0);
    return row;
  endfunction

  function automatic step_row_t cfg_row(input logic [CFG_W-1:0] cap);
    step_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cap = cap;
    return row;
  endfunction

  // Drive one transaction and queue its expected result once accepted
  task automatic issue(input logic op, input logic [ID_W-1:0] id, input logic [PRI_W-1:0] pri,
                       input bit calm, input bit typed, input heap_result_t want);
    int           gap;
    heap_result_t model_out;
    gap = pick_gap(calm);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    item_id <= id;
    item_priority <= pri;
    do @(posedge clk); while (busy);
    model_out = heap_predict(op, id, pri);
    results_due.push_back(typed ? want : model_out);
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_cap = value;
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $error("result with nothing expected: status %0d id %0h", status, out_id);
        err_count++;
      end else begin
        due_head = results_due.pop_front();
        if (status !== due_head.status) begin
          $error("status: expected %0d, got %0d", due_head.status, status);
          err_count++;
        end
        if (out_id !== due_head.id) begin
          $error("out_id: expected %0h, got %0h", due_head.id, out_id);
          err_count++;
        end
        if (out_priority !== due_head.pri) begin
          $error("out_priority: expected %0d, got %0d", $signed(due_head.pri), out_priority);
          err_count++;
        end
        if (entry_total !== due_head.total) begin
          $error("entry_total: expected %0d, got %0d", due_head.total, entry_total);
          err_count++;
        end
        if (is_empty !== due_head.empty) begin
          $error("is_empty: expected %0b, got %0b", due_head.empty, is_empty);
          err_count++;
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_cap [PHASES];
    int               phase_pct [PHASES];
    logic             op;
    step_row_t        row;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    operation = OP_INSERT;
    item_id = '0;
    item_priority = '0;
    err_count = 0;
    shadow_count = 0;
    shadow_cap = CFG_RESET;
    no_want = '0;

    // Extremes, ties, empty heap, zero and lowered capacity, saturation
    directed.push_back(typed_row(OP_EXTRACT, 16'h0, 32'h0, ST_EMPTY, 16'h0, 32'h0, 0));
    directed.push_back(typed_row(OP_INSERT, 16'hffff, 32'h7fff_ffff, ST_INSERTED, 0, 0, 1));
    directed.push_back(typed_row(OP_INSERT, 16'h0000, 32'h8000_0000, ST_INSERTED, 0, 0, 2));
    directed.push_back(typed_row(OP_INSERT, 16'h1234, 32'h0, ST_INSERTED, 0, 0, 3));
    directed.push_back(typed_row(OP_INSERT, 16'h0007, 32'hffff_ffff, ST_INSERTED, 0, 0, 4));
    directed.push_back(typed_row(OP_INSERT, 16'h0008, 32'd5, ST_INSERTED, 0, 0, 5));
    directed.push_back(typed_row(OP_INSERT, 16'h0009, 32'd5, ST_INSERTED, 0, 0, 6));
    directed.push_back(typed_row(OP_EXTRACT, 16'h0, 32'h0, ST_EXTRACTED, 16'hffff,
                                 32'h7fff_ffff, 5));
    repeat (5) directed.push_back(op_row(OP_EXTRACT, 16'h5a5a, 32'h1234_5678));
    directed.push_back(typed_row(OP_EXTRACT, 16'h0, 32'h0, ST_EMPTY, 16'h0, 32'h0, 0));
    for (int i = 1; i <= 4; i++) directed.push_back(op_row(OP_INSERT, ID_W'(16'h10 + i), 32'd100));
    repeat (2) directed.push_back(op_row(OP_EXTRACT, 16'h0, 32'h0));
    directed.push_back(cfg_row(7'd0));
    directed.push_back(typed_row(OP_INSERT, 16'h4444, 32'd9, ST_DROPPED, 0, 0, 2));
    directed.push_back(cfg_row(7'd1));
    directed.push_back(typed_row(OP_INSERT, 16'h5555, 32'd9, ST_DROPPED, 0, 0, 2));
    repeat (2) directed.push_back(op_row(OP_EXTRACT, 16'h0, 32'h0));
    directed.push_back(typed_row(OP_INSERT, 16'haaaa, 32'd55, ST_INSERTED, 0, 0, 1));
    directed.push_back(typed_row(OP_INSERT, 16'hbbbb, 32'd77, ST_DROPPED, 0, 0, 1));
    directed.push_back(cfg_row(7'd127));
    directed.push_back(typed_row(OP_EXTRACT, 16'h0, 32'h0, ST_EXTRACTED, 16'haaaa, 32'd55, 0));

    // Hold reset, then release on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_cfg) write_capacity(row.cap);
      else issue(row.op, row.id, row.pri, 1'b0, row.typed, row.want);
    end

    // Random phases: fill, lower capacity below count, zero, saturate, drain
    phase_cap = '{7'd64, 7'd5, 7'd0, 7'd127, 7'd1, 7'd2, 7'd33, 7'd64,
                  CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 127))};
    phase_pct = '{85, 50, 60, 55, 60, 55, 65, 85, 50, 20};
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < phase_pct[p]) ? OP_INSERT : OP_EXTRACT;
        issue(op, ID_W'($urandom), pick_priority(), (p % 3) == 1, 1'b0, no_want);
      end
    end

    // Let the last results arrive
    drain_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/mph_pkg.sv
src/mph_ram.sv
src/mph_ctrl.sv
src/mph_dpath.sv
src/max_priority_heap.sv
dv/tb_max_priority_heap.sv
